// File: rtl/core/pbn_pkg.sv
// ----------------------------------------------------------------------------
// pbn_pkg - shared types and constants
// Field widths, register map and the queue word passed from front to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbn_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int WEIGHT_BITS_DEF     = 12;

  localparam int FIELD_W   = 8;
  localparam int RGB_W     = 24;
  localparam int IN_DATA_W = 48;
  localparam int PCT_W     = 7;
  localparam int PCT_MAX   = 100;
  localparam logic [PCT_W-1:0] PCT_RESET = 7'd66;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // register index, taken from the word address bit
  typedef enum logic {
    REG_BLEND_PERCENT = 1'b0
  } reg_idx_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [FIELD_W-1:0] index;
    logic [RGB_W-1:0]   rgb;
    logic [FIELD_W-1:0] over;
    logic [FIELD_W-1:0] under;
    logic               ov_ok;
    logic               un_ok;
  } item_t;

endpackage

`default_nettype wire

// File: rtl/core/pbn_ram.sv
// ----------------------------------------------------------------------------
// pbn_ram - generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbn_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/pbn_front.sv
// ----------------------------------------------------------------------------
// pbn_front - input side
// Takes words from the input stream, sorts them into loads and queries,
// checks index ranges and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbn_front #(
  parameter int PALETTE_ENTRIES = pbn_pkg::PALETTE_ENTRIES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [pbn_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                           in_tuser,
  output pbn_pkg::item_t                      q_item,
  output logic                                q_valid,
  input  wire logic                           q_pop
);

  import pbn_pkg::*;

  localparam logic [FIELD_W:0] LIMIT = (FIELD_W+1)'(PALETTE_ENTRIES);

  item_t       item;
  logic        drop;
  logic        push;
  item_t       slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  always_comb begin
    item.op    = op_t'(in_tuser);
    item.index = in_tdata[7:0];
    item.rgb   = {in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]};
    item.over  = in_tdata[39:32];
    item.under = in_tdata[47:40];
    item.ov_ok = {1'b0, in_tdata[39:32]} < LIMIT;
    item.un_ok = {1'b0, in_tdata[47:40]} < LIMIT;
  end

  // a load beyond the palette has no effect, so it never enters the queue
  assign drop      = (item.op == OP_LOAD) && !({1'b0, item.index} < LIMIT);
  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready && !drop;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pbn_back.sv
// ----------------------------------------------------------------------------
// pbn_back - palette store and nearest-colour search
// Executes queued loads into the palette RAM; for a query derives the blend
// weights, blends the two colours and scans every entry through a
// three-stage error pipeline, keeping the smallest error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbn_back #(
  parameter int PALETTE_ENTRIES = pbn_pkg::PALETTE_ENTRIES_DEF,
  parameter int WEIGHT_BITS     = pbn_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  pbn_pkg::item_t                    q_item,
  input  wire logic                         q_valid,
  output logic                              q_pop,
  input  wire logic [pbn_pkg::PCT_W-1:0]    pct,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic      [pbn_pkg::FIELD_W-1:0]  out_tdata
);

  import pbn_pkg::*;

  localparam int IDX_W    = $clog2(PALETTE_ENTRIES);
  localparam int W_W      = WEIGHT_BITS + 1;
  localparam int S_W      = WEIGHT_BITS + 8;
  localparam int P_W      = S_W + 8;
  localparam int SQ_W     = 18;
  localparam int E_W      = WEIGHT_BITS + 20;
  localparam int NUM_W    = PCT_W + WEIGHT_BITS;
  localparam int RK       = NUM_W + 8;
  localparam int RECIP_W  = RK - 6;
  localparam int MUL_W    = NUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RK) / PCT_MAX);
  localparam logic [W_W-1:0]     W_ONE = W_W'(1) << WEIGHT_BITS;
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_RD_UN  = 8'b0000_0010,
    S_GET_OV = 8'b0000_0100,
    S_GET_UN = 8'b0000_1000,
    S_BLEND  = 8'b0001_0000,
    S_SCAN   = 8'b0010_0000,
    S_DRAIN  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  function automatic logic [S_W-1:0] blend(input logic [7:0] a, input logic [7:0] b,
                                           input logic [W_W-1:0] wa,
                                           input logic [W_W-1:0] wb);
    logic [S_W:0] sum;
    sum = (S_W+1)'(a) * (S_W+1)'(wa) + (S_W+1)'(b) * (S_W+1)'(wb);
    return sum[S_W-1:0];
  endfunction

  state_t state_r, state_nxt;

  // RAM
  logic             ram_we;
  logic [IDX_W-1:0] ram_raddr;
  logic [RGB_W-1:0] ram_rdata;

  // query setup
  logic [PCT_W-1:0] pct_sat;
  logic [NUM_W-1:0] num;
  logic [MUL_W-1:0] prod;
  logic [NUM_W-1:0] rem;
  logic [W_W-1:0]   q0_r;
  logic [W_W-1:0]   w1_r;
  logic [W_W-1:0]   w2;
  logic [FIELD_W-1:0] under_r;
  logic             ov_ok_r, un_ok_r;
  logic [RGB_W-1:0] ov_rgb_r, un_rgb_r;
  logic [S_W-1:0]   sr_r, sg_r, sb_r;
  logic [IDX_W-1:0] addr_r;

  // scan pipeline
  logic             rv_r, rlast_r;
  logic [IDX_W-1:0] ridx_r;
  logic             va_r, lasta_r;
  logic [IDX_W-1:0] idxa_r;
  logic [P_W-1:0]   pr_r, pg_r, pb_r;
  logic [SQ_W-1:0]  sq_r;
  logic             vb_r, lastb_r;
  logic [IDX_W-1:0] idxb_r;
  logic signed [E_W-1:0] err_r;
  logic [E_W-1:0]   tot, dot;
  logic [7:0]       cr, cg, cb;

  logic             have_r;
  logic signed [E_W-1:0] best_r;
  logic [IDX_W-1:0] best_idx_r;

  logic             out_valid_r;
  logic [FIELD_W-1:0] out_data_r;
  logic             out_load;

  pbn_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_item.index[IDX_W-1:0]),
    .wdata (q_item.rgb),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign q_pop  = (state_r == S_IDLE) && q_valid;
  assign ram_we = q_pop && (q_item.op == OP_LOAD);

  always_comb begin
    case (state_r)
      S_IDLE:  ram_raddr = q_item.over[IDX_W-1:0];
      S_RD_UN: ram_raddr = under_r[IDX_W-1:0];
      default: ram_raddr = addr_r;
    endcase
  end

  // w1 = floor(pct * 2^WEIGHT_BITS / 100): reciprocal estimate, then one fix-up
  assign pct_sat = (pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : pct;
  assign num     = {pct_sat, {WEIGHT_BITS{1'b0}}};
  assign prod    = MUL_W'(num) * MUL_W'(RECIP);
  assign rem     = num - NUM_W'(NUM_W'(q0_r) * NUM_W'(PCT_MAX));
  assign w2      = W_ONE - w1_r;

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid && q_item.op == OP_QUERY) begin
          state_nxt = S_RD_UN;
        end
      end
      S_RD_UN:  state_nxt = S_GET_OV;
      S_GET_OV: state_nxt = S_GET_UN;
      S_GET_UN: state_nxt = S_BLEND;
      S_BLEND:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (addr_r == '0) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (vb_r && lastb_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rv_r        <= 1'b0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= (state_r == S_SCAN);
      va_r    <= rv_r;
      vb_r    <= va_r;
      if (state_r == S_BLEND) begin
        have_r <= 1'b0;
      end else if (vb_r) begin
        have_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign cr  = ram_rdata[23:16];
  assign cg  = ram_rdata[15:8];
  assign cb  = ram_rdata[7:0];
  assign tot = E_W'(sq_r) << (WEIGHT_BITS - 1);
  assign dot = E_W'(pr_r) + E_W'(pg_r) + E_W'(pb_r);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      under_r <= q_item.under;
      ov_ok_r <= q_item.ov_ok;
      un_ok_r <= q_item.un_ok;
    end
    if (state_r == S_RD_UN) begin
      q0_r     <= W_W'(prod >> RK);
      // an index beyond the palette reads as black
      ov_rgb_r <= ov_ok_r ? ram_rdata : '0;
    end
    if (state_r == S_GET_OV) begin
      w1_r     <= (rem >= NUM_W'(PCT_MAX)) ? q0_r + W_W'(1) : q0_r;
      un_rgb_r <= un_ok_r ? ram_rdata : '0;
    end
    if (state_r == S_BLEND) begin
      sr_r   <= blend(ov_rgb_r[23:16], un_rgb_r[23:16], w1_r, w2);
      sg_r   <= blend(ov_rgb_r[15:8],  un_rgb_r[15:8],  w1_r, w2);
      sb_r   <= blend(ov_rgb_r[7:0],   un_rgb_r[7:0],   w1_r, w2);
      addr_r <= LAST_IDX;
    end else if (state_r == S_SCAN) begin
      addr_r <= addr_r - IDX_W'(1);
    end

    ridx_r  <= addr_r;
    rlast_r <= (addr_r == '0);

    idxa_r  <= ridx_r;
    lasta_r <= rlast_r;
    pr_r    <= P_W'(cr) * P_W'(sr_r);
    pg_r    <= P_W'(cg) * P_W'(sg_r);
    pb_r    <= P_W'(cb) * P_W'(sb_r);
    sq_r    <= SQ_W'(cr) * SQ_W'(cr) + SQ_W'(cg) * SQ_W'(cg) + SQ_W'(cb) * SQ_W'(cb);

    idxb_r  <= idxa_r;
    lastb_r <= lasta_r;
    err_r   <= $signed(tot - dot);

    // strict less: on a tie the earlier (higher) index stays
    if (vb_r && (!have_r || err_r < best_r)) begin
      best_r     <= err_r;
      best_idx_r <= idxb_r;
    end

    if (out_load) begin
      out_data_r <= FIELD_W'(best_idx_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/core/palette_blend_nearest_color_top.sv
// Loads: one word per cycle while the search engine is idle, no result.
// Query: the time from leaving the queue to the result register grows
// with PALETTE_ENTRIES, set by the one RAM read port, read once per entry.
// A two-word queue sits in front of the search engine; results wait in an
// output register. Reset clears control state and sets blend_percent to 66;
// the palette is not cleared and is undefined until loaded.
// ----------------------------------------------------------------------------
// palette_blend_nearest_color_top - blended nearest palette colour
// Streaming input of loads and queries, streaming result of best index,
// APB register for the blend percentage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module palette_blend_nearest_color_top #(
  parameter int PALETTE_ENTRIES = pbn_pkg::PALETTE_ENTRIES_DEF,
  parameter int WEIGHT_BITS     = pbn_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // entry_index[7:0] red[15:8] green[23:16] blue[31:24] over_color[39:32]
  // under_color[47:40]
  input  wire logic [pbn_pkg::IN_DATA_W-1:0] in_tdata,
  // kind
  input  wire logic                          in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // best_index[7:0]
  output logic      [pbn_pkg::FIELD_W-1:0]   out_tdata,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [pbn_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire logic [pbn_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic      [pbn_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  import pbn_pkg::*;

  logic [PCT_W-1:0] pct_r, pct_nxt;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;
  item_t            q_item;
  logic             q_valid;
  logic             q_pop;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    pct_nxt = pct_r;
    if (cfg_wr && cfg_idx == REG_BLEND_PERCENT) begin
      pct_nxt = cfg_pwdata[PCT_W-1:0];
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BLEND_PERCENT: cfg_prdata = CFG_DW'(pct_r);
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r <= PCT_RESET;
    end else begin
      pct_r <= pct_nxt;
    end
  end

  pbn_front #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop)
  );

  pbn_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .WEIGHT_BITS     (WEIGHT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .pct        (pct_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
